[hdl/sparse_polynomial_arithmetic_macros.svh]
// Assertion macros shared by the sparse polynomial block.
// Each macro expects clk and rst_n to be in scope at the place of use.
`ifndef SPARSE_POLYNOMIAL_ARITHMETIC_MACROS_SVH
`define SPARSE_POLYNOMIAL_ARITHMETIC_MACROS_SVH
`ifndef SYNTHESIS
`define SPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPA_ASSERT_IMP(lbl, ante, cons, msg)
`define SPA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/spa_pkg.sv]
// Types and codes shared by the sparse polynomial arithmetic block.
// No dependencies.
package spa_pkg;

    localparam int COEF_W    = 32;
    localparam int EXP_W     = 8;
    localparam int RES_EXP_W = 9;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_LOAD_A = 3'd1,
        CMD_LOAD_B = 3'd2,
        CMD_ADD    = 3'd3,
        CMD_SUB    = 3'd4,
        CMD_MUL    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_TERM  = 2'd0,
        STAT_ACK   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_PASS = 2'd0,
        ALU_NEG  = 2'd1,
        ALU_ADD  = 2'd2,
        ALU_MUL  = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic              go;
        alu_op_t           op;
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [COEF_W-1:0]    coef;
        logic [RES_EXP_W-1:0] expo;
    } work_entry_t;

endpackage

[hdl/spa_alu.sv]
// Shared saturating arithmetic unit: pass, negate, add and Q-format multiply.
// Depends on spa_pkg. The result is registered when a request is issued.
module spa_alu import spa_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  alu_req_t          req,
    output logic [COEF_W-1:0] result
);

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    logic signed [63:0]  product;
    logic signed [63:0]  wide;
    logic [COEF_W-1:0]   result_reg;
    logic [COEF_W-1:0]   result_next;

    always_comb
    begin
        product = 64'($signed(req.a)) * 64'($signed(req.b));
        unique case (req.op)
            ALU_PASS: wide = 64'($signed(req.a));
            ALU_NEG:  wide = -64'($signed(req.a));
            ALU_ADD:  wide = 64'($signed(req.a)) + 64'($signed(req.b));
            ALU_MUL:  wide = product >>> FRAC_BITS;
            default:  wide = 64'($signed(req.a));
        endcase
        if (wide > SAT_MAX)
        begin
            result_next = SAT_MAX[COEF_W-1:0];
        end
        else if (wide < SAT_MIN)
        begin
            result_next = SAT_MIN[COEF_W-1:0];
        end
        else
        begin
            result_next = wide[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[hdl/spa_work_mem.sv]
// Single-port work list memory with registered read data.
// Depends on spa_pkg for the entry type.
module spa_work_mem import spa_pkg::*; #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  work_entry_t       wdata,
    output work_entry_t       rdata
);

    work_entry_t mem_reg [DEPTH];
    work_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/sparse_polynomial_arithmetic.sv]
// Sparse polynomial add, subtract and multiply engine, top level.
// Depends on spa_pkg, spa_alu, spa_work_mem and the assertion macro header.
//
// Terms are loaded one per transfer into stores A and B; clear and load answer
// with a single status transfer. An arithmetic command forms raw terms one at a
// time in the shared arithmetic unit and merges each into the work list by
// scanning it entry by entry through the single-port work memory. The block takes
// no new input until the last result of the current command has been transferred.
`include "sparse_polynomial_arithmetic_macros.svh"
module sparse_polynomial_arithmetic import spa_pkg::*; #(
    parameter int TERMS     = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // coefficient [31:0], exponent [39:32]
    input  logic [2:0]  s_tuser,   // command [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // coefficient_out [31:0], exponent_out [40:32], zeros
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast
);

    localparam int WORK_DEPTH = TERMS * TERMS;
    localparam int CNT_W      = $clog2(TERMS + 1);
    localparam int IDX_W      = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int WCNT_W     = $clog2(WORK_DEPTH + 1);
    localparam int WADDR_W    = (WORK_DEPTH > 1) ? $clog2(WORK_DEPTH) : 1;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_FETCH    = 8'b0000_0010,
        ST_SCAN_RD  = 8'b0000_0100,
        ST_SCAN_CMP = 8'b0000_1000,
        ST_WRITE    = 8'b0001_0000,
        ST_EMIT_RD  = 8'b0010_0000,
        ST_EMIT_LD  = 8'b0100_0000,
        ST_EMIT_OUT = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [CNT_W-1:0]     a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0]     b_cnt_reg, b_cnt_next;
    logic [WCNT_W-1:0]    w_cnt_reg, w_cnt_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [WCNT_W-1:0]    k_reg, k_next;
    logic [RES_EXP_W-1:0] term_exp_reg, term_exp_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_last_reg, m_last_next;
    status_t              m_status_reg, m_status_next;
    logic [COEF_W-1:0]    m_coef_reg, m_coef_next;
    logic [RES_EXP_W-1:0] m_exp_reg, m_exp_next;

    logic [COEF_W-1:0]    a_coef_reg [TERMS];
    logic [EXP_W-1:0]     a_exp_reg  [TERMS];
    logic [COEF_W-1:0]    b_coef_reg [TERMS];
    logic [EXP_W-1:0]     b_exp_reg  [TERMS];
    logic                 a_we, b_we;

    alu_req_t             alu_req;
    logic [COEF_W-1:0]    alu_res;
    logic                 mem_we, mem_re;
    work_entry_t          mem_wdata, mem_rdata;

    logic [COEF_W-1:0]    a_coef_sel, b_coef_sel;
    logic [EXP_W-1:0]     a_exp_sel, b_exp_sel;

    assign a_coef_sel = a_coef_reg[i_reg[IDX_W-1:0]];
    assign a_exp_sel  = a_exp_reg[i_reg[IDX_W-1:0]];
    assign b_coef_sel = b_coef_reg[j_reg[IDX_W-1:0]];
    assign b_exp_sel  = b_exp_reg[j_reg[IDX_W-1:0]];

    spa_alu #(
        .FRAC_BITS(FRAC_BITS)
    ) u_alu (
        .clk    (clk),
        .req    (alu_req),
        .result (alu_res)
    );

    spa_work_mem #(
        .DEPTH (WORK_DEPTH),
        .ADDR_W(WADDR_W)
    ) u_work_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (k_reg[WADDR_W-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        a_cnt_next    = a_cnt_reg;
        b_cnt_next    = b_cnt_reg;
        w_cnt_next    = w_cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        term_exp_next = term_exp_reg;
        m_valid_next  = m_valid_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;
        m_coef_next   = m_coef_reg;
        m_exp_next    = m_exp_reg;
        a_we          = 1'b0;
        b_we          = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_wdata     = '{coef: alu_res, expo: term_exp_reg};
        alu_req       = '{go: 1'b0, op: ALU_PASS, a: '0, b: '0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    m_coef_next   = '0;
                    m_exp_next    = '0;
                    m_last_next   = 1'b1;
                    m_status_next = STAT_ACK;
                    unique case (s_tuser)
                        CMD_CLEAR:
                        begin
                            a_cnt_next   = '0;
                            b_cnt_next   = '0;
                            w_cnt_next   = '0;
                            m_valid_next = 1'b1;
                            state_next   = ST_EMIT_OUT;
                        end
                        CMD_LOAD_A:
                        begin
                            if (a_cnt_reg == CNT_W'(TERMS))
                            begin
                                m_status_next = STAT_FULL;
                            end
                            else
                            begin
                                a_we       = 1'b1;
                                a_cnt_next = a_cnt_reg + 1'b1;
                            end
                            m_valid_next = 1'b1;
                            state_next   = ST_EMIT_OUT;
                        end
                        CMD_LOAD_B:
                        begin
                            if (b_cnt_reg == CNT_W'(TERMS))
                            begin
                                m_status_next = STAT_FULL;
                            end
                            else
                            begin
                                b_we       = 1'b1;
                                b_cnt_next = b_cnt_reg + 1'b1;
                            end
                            m_valid_next = 1'b1;
                            state_next   = ST_EMIT_OUT;
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL:
                        begin
                            cmd_next   = cmd_t'(s_tuser);
                            w_cnt_next = '0;
                            i_next     = '0;
                            j_next     = '0;
                            state_next = ST_FETCH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (cmd_reg == CMD_MUL && i_reg < a_cnt_reg && j_reg < b_cnt_reg)
                begin
                    alu_req       = '{go: 1'b1, op: ALU_MUL, a: a_coef_sel, b: b_coef_sel};
                    term_exp_next = RES_EXP_W'(a_exp_sel) + RES_EXP_W'(b_exp_sel);
                    if (j_reg == b_cnt_reg - 1'b1)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    k_next     = '0;
                    state_next = ST_SCAN_RD;
                end
                else if (cmd_reg != CMD_MUL && i_reg < a_cnt_reg)
                begin
                    alu_req       = '{go: 1'b1, op: ALU_PASS, a: a_coef_sel, b: '0};
                    term_exp_next = RES_EXP_W'(a_exp_sel);
                    i_next        = i_reg + 1'b1;
                    k_next        = '0;
                    state_next    = ST_SCAN_RD;
                end
                else if (cmd_reg != CMD_MUL && j_reg < b_cnt_reg)
                begin
                    alu_req = '{go: 1'b1, op: (cmd_reg == CMD_SUB) ? ALU_NEG : ALU_PASS,
                                a: b_coef_sel, b: '0};
                    term_exp_next = RES_EXP_W'(b_exp_sel);
                    j_next        = j_reg + 1'b1;
                    k_next        = '0;
                    state_next    = ST_SCAN_RD;
                end
                else if (w_cnt_reg == '0)
                begin
                    m_coef_next   = '0;
                    m_exp_next    = '0;
                    m_last_next   = 1'b1;
                    m_status_next = STAT_EMPTY;
                    m_valid_next  = 1'b1;
                    state_next    = ST_EMIT_OUT;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (k_reg == w_cnt_reg)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (mem_rdata.expo == term_exp_reg)
                begin
                    alu_req    = '{go: 1'b1, op: ALU_ADD, a: mem_rdata.coef, b: alu_res};
                    state_next = ST_WRITE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_WRITE:
            begin
                if (k_reg < WCNT_W'(WORK_DEPTH))
                begin
                    mem_we = 1'b1;
                    if (k_reg == w_cnt_reg)
                    begin
                        w_cnt_next = w_cnt_reg + 1'b1;
                    end
                end
                state_next = ST_FETCH;
            end
            ST_EMIT_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                m_coef_next   = mem_rdata.coef;
                m_exp_next    = mem_rdata.expo;
                m_status_next = STAT_TERM;
                m_last_next   = (WCNT_W'(k_reg + 1'b1) == w_cnt_reg);
                m_valid_next  = 1'b1;
                state_next    = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (m_tready)
                begin
                    m_valid_next = 1'b0;
                    if (m_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmd_reg     <= CMD_CLEAR;
            a_cnt_reg   <= '0;
            b_cnt_reg   <= '0;
            w_cnt_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            a_cnt_reg   <= a_cnt_next;
            b_cnt_reg   <= b_cnt_next;
            w_cnt_reg   <= w_cnt_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            m_last_reg  <= m_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_exp_reg <= term_exp_next;
        m_status_reg <= m_status_next;
        m_coef_reg   <= m_coef_next;
        m_exp_reg    <= m_exp_next;
        if (a_we)
        begin
            a_coef_reg[a_cnt_reg[IDX_W-1:0]] <= s_tdata[31:0];
            a_exp_reg[a_cnt_reg[IDX_W-1:0]]  <= s_tdata[39:32];
        end
        if (b_we)
        begin
            b_coef_reg[b_cnt_reg[IDX_W-1:0]] <= s_tdata[31:0];
            b_exp_reg[b_cnt_reg[IDX_W-1:0]]  <= s_tdata[39:32];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_exp_reg, m_coef_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    `SPA_ASSERT_IMP(a_idle_no_result, state_reg == ST_IDLE, !m_valid_reg, "Result pending while idle")
    `SPA_ASSERT_IMP(a_work_bound, 1'b1, w_cnt_reg <= WCNT_W'(WORK_DEPTH), "Work list overflow")
    `SPA_ASSERT_IMP(a_store_bound, 1'b1, a_cnt_reg <= CNT_W'(TERMS) && b_cnt_reg <= CNT_W'(TERMS), "Store count overflow")
    `SPA_ASSERT_IMP(a_status_last, m_valid_reg && m_status_reg != STAT_TERM, m_last_reg, "Status transfer without last")
    `SPA_ASSERT_NXT(a_last_to_idle, m_valid_reg && m_tready && m_last_reg, state_reg == ST_IDLE, "No return to idle after last")

endmodule

[sim/tb_sparse_polynomial_arithmetic.sv]
// Testbench for the sparse polynomial arithmetic block: drives load, clear and
// arithmetic commands as stream transfers and checks every result transfer
// against a behavioral predictor. Depends on spa_pkg and the block itself.
module tb_sparse_polynomial_arithmetic;
    import spa_pkg::*;

    localparam int NTERMS = 8;
    localparam int FRAC   = 16;
    localparam longint CYCLE_LIMIT = 5000000;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] coef;
        logic [7:0]  expo;
    } term_cmd_t;

    typedef struct {
        logic [31:0] coef;
        logic [8:0]  expo;
        logic [1:0]  status;
        logic        last;
    } poly_out_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [39:0] s_tdata;
    logic [2:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [47:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    sparse_polynomial_arithmetic #(.TERMS(NTERMS), .FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    term_cmd_t pending_cmds[$];
    poly_out_t expected_terms[$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    bit send_pause;
    longint cycle_count;
    int results_seen;
    int cmds_sent;

    // Predictor state.
    logic signed [31:0] pa_coef[NTERMS];
    logic [7:0] pa_expo[NTERMS];
    int pa_count;
    logic signed [31:0] pb_coef[NTERMS];
    logic [7:0] pb_expo[NTERMS];
    int pb_count;
    logic signed [31:0] wk_coef[64];
    logic [8:0] wk_expo[64];
    int wk_count;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic signed [31:0] saturate(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fixed_product(logic signed [31:0] x,
                                                          logic signed [31:0] y);
        longint p;
        p = longint'(x) * longint'(y);
        return saturate(p >>> FRAC);
    endfunction

    function automatic void merge_into_work(logic signed [31:0] c, logic [8:0] e);
        for (int i = 0; i < wk_count; i++)
        begin
            if (wk_expo[i] == e)
            begin
                wk_coef[i] = saturate(longint'(wk_coef[i]) + longint'(c));
                return;
            end
        end
        if (wk_count < 64)
        begin
            wk_coef[wk_count] = c;
            wk_expo[wk_count] = e;
            wk_count++;
        end
    endfunction

    function automatic void push_status(status_t st);
        poly_out_t r;
        r.coef = '0;
        r.expo = '0;
        r.status = st;
        r.last = 1'b1;
        expected_terms.push_back(r);
    endfunction

    function automatic void predict_poly(term_cmd_t t);
        poly_out_t r;
        logic signed [31:0] c;
        case (t.cmd)
            CMD_CLEAR:
            begin
                pa_count = 0;
                pb_count = 0;
                wk_count = 0;
                push_status(STAT_ACK);
            end
            CMD_LOAD_A:
            begin
                if (pa_count >= NTERMS)
                    push_status(STAT_FULL);
                else
                begin
                    pa_coef[pa_count] = t.coef;
                    pa_expo[pa_count] = t.expo;
                    pa_count++;
                    push_status(STAT_ACK);
                end
            end
            CMD_LOAD_B:
            begin
                if (pb_count >= NTERMS)
                    push_status(STAT_FULL);
                else
                begin
                    pb_coef[pb_count] = t.coef;
                    pb_expo[pb_count] = t.expo;
                    pb_count++;
                    push_status(STAT_ACK);
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL:
            begin
                wk_count = 0;
                if (t.cmd == CMD_MUL)
                begin
                    for (int i = 0; i < pa_count; i++)
                        for (int j = 0; j < pb_count; j++)
                            merge_into_work(fixed_product(pa_coef[i], pb_coef[j]),
                                            9'(pa_expo[i]) + 9'(pb_expo[j]));
                end
                else
                begin
                    for (int i = 0; i < pa_count; i++)
                        merge_into_work(pa_coef[i], 9'(pa_expo[i]));
                    for (int j = 0; j < pb_count; j++)
                    begin
                        c = pb_coef[j];
                        if (t.cmd == CMD_SUB)
                            c = saturate(-longint'(c));
                        merge_into_work(c, 9'(pb_expo[j]));
                    end
                end
                if (wk_count == 0)
                    push_status(STAT_EMPTY);
                for (int i = 0; i < wk_count; i++)
                begin
                    r.coef = wk_coef[i];
                    r.expo = wk_expo[i];
                    r.status = STAT_TERM;
                    r.last = (i == wk_count - 1);
                    expected_terms.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void queue_cmd(logic [2:0] cmd, logic [31:0] coef, logic [7:0] expo);
        term_cmd_t t;
        t.cmd = cmd;
        t.coef = coef;
        t.expo = expo;
        pending_cmds.push_back(t);
    endfunction

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 8)) << 16;
            3: return -(32'($urandom_range(1, 8)) << 16);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] random_expo();
        if ($urandom_range(0, 2) == 0)
            return 8'($urandom_range(0, 3));
        return 8'($urandom());
    endfunction

    // One sequence: clear, load both stores, a few operations, at times one random command code.
    function automatic void queue_random_sequence();
        int na;
        int nb;
        queue_cmd(CMD_CLEAR, $urandom(), $urandom());
        na = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : $urandom_range(0, 4);
        nb = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : $urandom_range(0, 4);
        for (int i = 0; i < na; i++)
            queue_cmd(CMD_LOAD_A, random_coef(), random_expo());
        for (int i = 0; i < nb; i++)
            queue_cmd(CMD_LOAD_B, random_coef(), random_expo());
        for (int i = $urandom_range(1, 3); i > 0; i--)
            queue_cmd(3'($urandom_range(CMD_ADD, CMD_MUL)), $urandom(), $urandom());
        if ($urandom_range(0, 4) == 0)
            queue_cmd(3'($urandom_range(0, 7)), $urandom(), $urandom());
    endfunction

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                predict_poly(pending_cmds.pop_front());
                cmds_sent++;
            end
            if (pending_cmds.size() > 0 && !send_pause &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {pending_cmds[0].expo, pending_cmds[0].coef};
                s_tuser <= pending_cmds[0].cmd;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge clk or negedge rst_n)
    begin
        poly_out_t exp_r;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_terms.size() == 0)
                begin
                    $error("unexpected result transfer: data %h status %0d", m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    exp_r = expected_terms.pop_front();
                    if (m_tdata[31:0] !== exp_r.coef)
                    begin
                        $error("coefficient_out: expected %h, actual %h", exp_r.coef,
                               m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[40:32] !== exp_r.expo)
                    begin
                        $error("exponent_out: expected %0d, actual %0d", exp_r.expo,
                               m_tdata[40:32]);
                        errors++;
                    end
                    if (m_tuser !== exp_r.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== exp_r.last)
                    begin
                        $error("last: expected %0d, actual %0d", exp_r.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_tvalid || expected_terms.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        cycle_count = 0;
        results_seen = 0;
        cmds_sent = 0;
        hold_cycles = 0;
        send_pause = 0;
        send_idle_pct = 26;
        recv_idle_pct = 52;
        pa_count = 0;
        pb_count = 0;
        wk_count = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty results, extremes, saturation, full stores, unused codes.
        queue_cmd(CMD_ADD, 0, 0);
        queue_cmd(CMD_MUL, 0, 0);
        queue_cmd(3'd6, 32'hffffffff, 8'hff);
        queue_cmd(3'd7, 0, 0);
        queue_cmd(CMD_LOAD_A, 32'h7fffffff, 8'hff);
        queue_cmd(CMD_LOAD_A, 32'h7fffffff, 8'hff);
        queue_cmd(CMD_LOAD_A, 32'h80000000, 8'h00);
        queue_cmd(CMD_LOAD_B, 32'h80000000, 8'hff);
        queue_cmd(CMD_LOAD_B, 32'hffffffff, 8'h00);
        queue_cmd(CMD_SUB, 0, 0);
        queue_cmd(CMD_ADD, 0, 0);
        queue_cmd(CMD_MUL, 0, 0);
        for (int i = 0; i < 6; i++)
            queue_cmd(CMD_LOAD_B, 32'hffff0000 + i, 8'(i * 51));
        queue_cmd(CMD_LOAD_B, 32'h00010000, 8'h01);
        queue_cmd(CMD_MUL, 0, 0);
        queue_cmd(CMD_CLEAR, 32'hffffffff, 8'hff);
        queue_cmd(CMD_SUB, 0, 0);
        wait_drained();

        // The receiver holds off while the sender keeps offering.
        for (int i = 0; i < 8; i++)
            queue_cmd(CMD_LOAD_A, random_coef(), random_expo());
        queue_cmd(CMD_ADD, 0, 0);
        hold_cycles = 400;
        wait_drained();

        while (pending_cmds.size() + cmds_sent < 90)
            queue_random_sequence();
        wait_drained();

        send_idle_pct = 52;
        recv_idle_pct = 26;
        while (pending_cmds.size() + cmds_sent < 160)
            queue_random_sequence();
        wait_drained();

        // The sender pauses until all outstanding results are in.
        send_pause = 1;
        queue_random_sequence();
        repeat (50) @(posedge clk);
        while (expected_terms.size() > 0)
            @(posedge clk);
        send_pause = 0;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (pending_cmds.size() + cmds_sent < 200)
            queue_random_sequence();
        wait_drained();
        repeat (200) @(posedge clk);

        $display("Sent %0d commands and checked %0d result transfers.", cmds_sent,
                 results_seen);
        $display("Covered loads, full stores, clears, add, subtract, multiply and stalls.");
        if (errors == 0 && expected_terms.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/spa_pkg.sv
hdl/spa_alu.sv
hdl/spa_work_mem.sv
hdl/sparse_polynomial_arithmetic.sv
sim/tb_sparse_polynomial_arithmetic.sv
